### rtl/irc_tok_pkg.sv
// ----------------------------------------------------------------------------
// IRC line tokenizer package
// Phase and token kind codes, the result record and character helpers.
// ----------------------------------------------------------------------------
package irc_tok_pkg;

    localparam int DEFAULT_MAX_PARAMS = 16;

    localparam logic [3:0] PH_LINE_START = 4'd0;
    localparam logic [3:0] PH_NICK_START = 4'd1;
    localparam logic [3:0] PH_NICK       = 4'd2;
    localparam logic [3:0] PH_USER_START = 4'd3;
    localparam logic [3:0] PH_USER       = 4'd4;
    localparam logic [3:0] PH_HOST_START = 4'd5;
    localparam logic [3:0] PH_HOST       = 4'd6;
    localparam logic [3:0] PH_PRE_CMD    = 4'd7;
    localparam logic [3:0] PH_CMD        = 4'd8;
    localparam logic [3:0] PH_PRE_PARAM  = 4'd9;
    localparam logic [3:0] PH_PARAM      = 4'd10;
    localparam logic [3:0] PH_TRAILING   = 4'd11;

    localparam logic [3:0] K_SKIP     = 4'd0;
    localparam logic [3:0] K_NICK     = 4'd1;
    localparam logic [3:0] K_USER     = 4'd2;
    localparam logic [3:0] K_HOST     = 4'd3;
    localparam logic [3:0] K_CMD      = 4'd4;
    localparam logic [3:0] K_PARAM    = 4'd5;
    localparam logic [3:0] K_TRAIL    = 4'd6;
    localparam logic [3:0] K_DELIM    = 4'd7;
    localparam logic [3:0] K_LINE_END = 4'd8;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data;
        logic [3:0] pnum;
        logic       begins;
        logic       done;
    } tok_result_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return ((b >= CH_LOW_A) && (b <= CH_LOW_Z)) ? (b - CASE_OFS) : b;
    endfunction

endpackage

### rtl/irc_line_tokenizer.sv
// ----------------------------------------------------------------------------
// IRC line tokenizer
// Classifies each received byte of an IRC message stream by its line role.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel rx_valid / rx_stall / rx_byte carries one received byte per
//   transaction. Output channel tok_valid / tok_stall carries one result per
//   input byte: token_kind, out_byte, param_number, token_begins, line_done.
//   Results are registered: a byte accepted in one cycle shows its result
//   from the next. Throughput is one byte per cycle unless the receiver
//   stalls; phase, parameter and content registers update at each accepted
//   byte by short logic. The result register frees as it is taken, so a new
//   byte is accepted in the same cycle that the previous result leaves.
//   When the receiver stalls, the result holds and rx_stall rises until it
//   is taken.
//   Reset returns the parser to line start with parameter index zero and
//   empties the result register.
// ----------------------------------------------------------------------------
module irc_line_tokenizer
    import irc_tok_pkg::*;
#(
    parameter int MAX_PARAMS = DEFAULT_MAX_PARAMS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       tok_valid,
    input  logic       tok_stall,
    output logic [3:0] token_kind,
    output logic [7:0] out_byte,
    output logic [3:0] param_number,
    output logic       token_begins,
    output logic       line_done
);

    localparam int         CAP_INT   = (MAX_PARAMS - 1 > 15) ? 15 : MAX_PARAMS - 1;
    localparam logic [3:0] PARAM_CAP = 4'(CAP_INT);

    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  param_reg, param_next;
    logic        content_reg, content_next;
    logic        valid_reg;
    tok_result_t result_reg, result_next;
    logic        accept;

    assign rx_stall = valid_reg && tok_stall;
    assign accept   = rx_valid && !rx_stall;

    always_comb
    begin
        phase_next   = phase_reg;
        param_next   = param_reg;
        content_next = 1'b1;
        result_next  = '{kind: K_SKIP, data: rx_byte, pnum: 4'd0,
                         begins: 1'b0, done: 1'b0};
        if ((rx_byte == CH_CR) || (rx_byte == CH_LF))
        begin
            result_next.kind = K_LINE_END;
            result_next.done = content_reg;
            phase_next       = PH_LINE_START;
            param_next       = 4'd0;
            content_next     = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_LINE_START:
                begin
                    if (rx_byte == CH_COLON)
                    begin
                        result_next.kind = K_DELIM;
                        phase_next       = PH_NICK_START;
                    end
                    else if (is_ws(rx_byte))
                    begin
                        phase_next = PH_PRE_PARAM;
                    end
                    else
                    begin
                        result_next.kind   = K_CMD;
                        result_next.data   = to_upper(rx_byte);
                        result_next.begins = 1'b1;
                        phase_next         = PH_CMD;
                    end
                end
                PH_NICK_START, PH_NICK:
                begin
                    if (rx_byte == CH_BANG)
                    begin
                        result_next.kind = K_DELIM;
                        phase_next       = PH_USER_START;
                    end
                    else if (rx_byte == CH_SPACE)
                    begin
                        phase_next = PH_PRE_CMD;
                    end
                    else
                    begin
                        result_next.kind   = K_NICK;
                        result_next.begins = (phase_reg == PH_NICK_START);
                        phase_next         = PH_NICK;
                    end
                end
                PH_USER_START, PH_USER:
                begin
                    if (rx_byte == CH_AT)
                    begin
                        result_next.kind = K_DELIM;
                        phase_next       = PH_HOST_START;
                    end
                    else if (rx_byte == CH_SPACE)
                    begin
                        phase_next = PH_PRE_CMD;
                    end
                    else
                    begin
                        result_next.kind   = K_USER;
                        result_next.begins = (phase_reg == PH_USER_START);
                        phase_next         = PH_USER;
                    end
                end
                PH_HOST_START, PH_HOST:
                begin
                    if (is_ws(rx_byte))
                    begin
                        phase_next = PH_PRE_CMD;
                    end
                    else
                    begin
                        result_next.kind   = K_HOST;
                        result_next.begins = (phase_reg == PH_HOST_START);
                        phase_next         = PH_HOST;
                    end
                end
                PH_PRE_CMD, PH_CMD:
                begin
                    if (is_ws(rx_byte))
                    begin
                        phase_next = (phase_reg == PH_CMD) ? PH_PRE_PARAM : PH_PRE_CMD;
                    end
                    else
                    begin
                        result_next.kind   = K_CMD;
                        result_next.data   = to_upper(rx_byte);
                        result_next.begins = (phase_reg == PH_PRE_CMD);
                        phase_next         = PH_CMD;
                    end
                end
                PH_PRE_PARAM:
                begin
                    if (is_ws(rx_byte))
                    begin
                        phase_next = PH_PRE_PARAM;
                    end
                    else if (rx_byte == CH_COLON)
                    begin
                        result_next.kind   = K_DELIM;
                        result_next.pnum   = param_reg;
                        result_next.begins = 1'b1;
                        phase_next         = PH_TRAILING;
                    end
                    else
                    begin
                        result_next.kind   = K_PARAM;
                        result_next.pnum   = param_reg;
                        result_next.begins = 1'b1;
                        phase_next         = PH_PARAM;
                    end
                end
                PH_PARAM:
                begin
                    if (is_ws(rx_byte))
                    begin
                        if (param_reg < PARAM_CAP)
                        begin
                            param_next = param_reg + 4'd1;
                        end
                        phase_next = PH_PRE_PARAM;
                    end
                    else
                    begin
                        result_next.kind = K_PARAM;
                        result_next.pnum = param_reg;
                    end
                end
                default:
                begin
                    result_next.kind = K_TRAIL;
                    result_next.pnum = param_reg;
                    phase_next       = PH_TRAILING;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LINE_START;
            param_reg   <= 4'd0;
            content_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                param_reg   <= param_next;
                content_reg <= content_next;
                valid_reg   <= 1'b1;
            end
            else if (!tok_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign tok_valid    = valid_reg;
    assign token_kind   = result_reg.kind;
    assign out_byte     = result_reg.data;
    assign param_number = result_reg.pnum;
    assign token_begins = result_reg.begins;
    assign line_done    = result_reg.done;

    a_done_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && line_done |-> token_kind == K_LINE_END)
        else $error("line_done set on a non-terminator result");

    a_pnum_kind: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (param_number != 4'd0) |->
            (token_kind == K_PARAM) || (token_kind == K_TRAIL) || (token_kind == K_DELIM))
        else $error("param_number set on a kind that carries none");

    a_param_cap: assert property (@(posedge clk) disable iff (!rst_n)
        param_reg <= PARAM_CAP)
        else $error("parameter index beyond its cap");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && !rx_stall |=> tok_valid)
        else $error("accepted byte produced no result");

    a_empty_line: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ((rx_byte == CH_CR) || (rx_byte == CH_LF)) |=> content_reg == 1'b0)
        else $error("line content flag not cleared at terminator");

endmodule
